[hw/rtl/sfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants and sideband type for the sample frame / time converter.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned RATE_W = 20;
  localparam int unsigned DSR_W  = 30;
  localparam int unsigned PROD_W = 52;

  localparam logic [DSR_W-1:0]  NS_PER_SEC = 30'd1000000000;
  localparam logic [31:0]       SEC_MAX    = 32'd2147483647;
  localparam logic [29:0]       NSEC_MAX   = 30'd999999999;
  localparam logic [RATE_W-1:0] RATE_RESET = 20'd48000;

  localparam logic CMD_FRAME_TO_TIME = 1'b0;
  localparam logic CMD_TIME_TO_FRAME = 1'b1;

  // Travels alongside each request through both divider chains.
  typedef struct packed {
    logic              cmd;
    logic              neg;
    logic              rzero;
    logic              sat;
    logic [RATE_W-1:0] rate;
    logic [31:0]       sec;
    logic [PROD_W-1:0] prod;
  } sfc_side_t;

endpackage

[hw/rtl/sample_frame_time_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_frame_time_converter
// Converts sample frame counts to seconds/nanoseconds and back.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle while the two-entry output queue is
// not full. It holds two rows of one-bit division cells, the first sized by
// the wider of the frame and the nanosecond total, the second 50 bits for the
// fractional part. Frame to time divides by sample_rate; time to frame
// divides by 1e9 and scales by sample_rate. Results beyond range saturate
// with overflow set; a zero rate gives overflow on frame to time.
// sample_rate is latched per request.
module sample_frame_time_converter #(
  parameter int unsigned FRAME_BITS = 52
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfc_pkg::RATE_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic signed [FRAME_BITS-1:0]      frame_in_i,
  input  logic signed [31:0]                seconds_in_i,
  input  logic signed [30:0]                nanoseconds_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [FRAME_BITS-1:0]      frame_out_o,
  output logic signed [31:0]                seconds_out_o,
  output logic signed [30:0]                nanoseconds_out_o,
  output logic                              overflow_o
);
  import sfc_pkg::*;

  localparam int unsigned WA = (FRAME_BITS > 62) ? FRAME_BITS : 62;
  localparam int unsigned WB = 50;

  logic              en;
  logic [RATE_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // ---- stage 1: magnitudes and seconds * 1e9
  logic                  p1_valid_q;
  logic                  p1_cmd_q;
  logic [RATE_W-1:0]     p1_rate_q;
  logic                  p1_fneg_q;
  logic [FRAME_BITS-1:0] p1_fmag_q;
  logic                  p1_sneg_q;
  logic                  p1_nneg_q;
  logic [61:0]           p1_big_q;
  logic [30:0]           p1_nmag_q;
  logic [31:0]           smag;
  logic [FRAME_BITS-1:0] fmag;
  logic [30:0]           nmag;

  always_comb begin
    fmag = frame_in_i[FRAME_BITS-1] ? (~frame_in_i + 1'b1) : frame_in_i;
    smag = seconds_in_i[31] ? (~seconds_in_i + 1'b1) : seconds_in_i;
    nmag = nanoseconds_in_i[30] ? (~nanoseconds_in_i + 1'b1) : nanoseconds_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_cmd_q  <= command_i;
      p1_rate_q <= rate_q;
      p1_fneg_q <= frame_in_i[FRAME_BITS-1];
      p1_fmag_q <= fmag;
      p1_sneg_q <= seconds_in_i[31];
      p1_nneg_q <= nanoseconds_in_i[30];
      p1_big_q  <= {30'd0, smag} * {32'd0, NS_PER_SEC};
      p1_nmag_q <= nmag;
    end
  end

  // ---- stage 2: signed total, dividend for the first row
  logic [61:0]      nmag_x;
  logic [61:0]      tot;
  logic             tneg;
  logic [61:0]      a_val;
  logic             a_valid;
  sfc_side_t        a_side;
  logic [WA-1:0]    a_dvd;
  logic [DSR_W-1:0] a_dsr;
  logic             a_valid_q;
  sfc_side_t        a_side_q;
  logic [WA-1:0]    a_dvd_q;
  logic [DSR_W-1:0] a_dsr_q;

  always_comb begin
    nmag_x = {31'd0, p1_nmag_q};
    if (p1_sneg_q == p1_nneg_q) begin
      tot  = p1_big_q + nmag_x;
      tneg = p1_sneg_q;
    end else if (p1_big_q >= nmag_x) begin
      tot  = p1_big_q - nmag_x;
      tneg = p1_sneg_q;
    end else begin
      tot  = nmag_x - p1_big_q;
      tneg = p1_nneg_q;
    end
    if (tot == '0) tneg = 1'b0;
    a_val = tot + 62'd1;

    a_valid      = p1_valid_q;
    a_side       = '0;
    a_side.cmd   = p1_cmd_q;
    a_side.rate  = p1_rate_q;
    a_side.rzero = (p1_rate_q == '0);
    if (p1_cmd_q == CMD_TIME_TO_FRAME) begin
      a_side.neg = tneg;
      a_dvd      = {{(WA-62){1'b0}}, a_val};
      a_dsr      = NS_PER_SEC;
    end else begin
      a_side.neg = p1_fneg_q;
      a_dvd      = {{(WA-FRAME_BITS){1'b0}}, p1_fmag_q};
      a_dsr      = {{(DSR_W-RATE_W){1'b0}}, p1_rate_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= a_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= a_side;
      a_dvd_q  <= a_dvd;
      a_dsr_q  <= a_dsr;
    end
  end

  logic             ra_valid;
  sfc_side_t        ra_side;
  logic [WA-1:0]    ra_quo;
  logic [DSR_W-1:0] ra_rem;

  sfc_div_chain #(.W(WA)) u_row_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .side_i  (a_side_q),
    .dvd_i   (a_dvd_q),
    .dsr_i   (a_dsr_q),
    .valid_o (ra_valid),
    .side_o  (ra_side),
    .quo_o   (ra_quo),
    .rem_o   (ra_rem)
  );

  // ---- stage 3: seconds clamp, remainder scaling, whole-second frames
  sfc_side_t        m_side;
  logic [DSR_W-1:0] m_mulb;
  logic [59:0]      m_prod;
  logic             b_valid_q;
  sfc_side_t        b_side_q;
  logic [WB-1:0]    b_dvd_q;
  logic [DSR_W-1:0] b_dsr_q;
  logic [DSR_W-1:0] b_dsr;

  always_comb begin
    m_side = ra_side;
    if (ra_side.cmd == CMD_TIME_TO_FRAME) begin
      m_mulb      = {{(DSR_W-RATE_W){1'b0}}, ra_side.rate};
      b_dsr       = NS_PER_SEC;
      m_side.prod = ra_quo[31:0] * ra_side.rate;
    end else begin
      m_mulb     = NS_PER_SEC;
      b_dsr      = {{(DSR_W-RATE_W){1'b0}}, ra_side.rate};
      m_side.sat = (ra_quo > {{(WA-32){1'b0}}, SEC_MAX});
      m_side.sec = m_side.sat ? SEC_MAX : ra_quo[31:0];
    end
    m_prod = ra_rem * m_mulb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= ra_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q <= m_side;
      b_dvd_q  <= m_prod[WB-1:0];
      b_dsr_q  <= b_dsr;
    end
  end

  logic             rb_valid;
  sfc_side_t        rb_side;
  logic [WB-1:0]    rb_quo;
  logic [DSR_W-1:0] rb_rem;

  sfc_div_chain #(.W(WB)) u_row_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .side_i  (b_side_q),
    .dvd_i   (b_dvd_q),
    .dsr_i   (b_dsr_q),
    .valid_o (rb_valid),
    .side_o  (rb_side),
    .quo_o   (rb_quo),
    .rem_o   (rb_rem)
  );

  // ---- final: sum, saturation, sign
  localparam logic [WA-1:0] FMAX = {{(WA-FRAME_BITS+1){1'b0}}, {(FRAME_BITS-1){1'b1}}};

  logic [WA-1:0]         f_sum;
  logic [FRAME_BITS-1:0] f_mag;
  logic [29:0]           ns_mag;
  logic [FRAME_BITS-1:0] r_frame;
  logic [31:0]           r_sec;
  logic [30:0]           r_nsec;
  logic                  r_ovf;
  logic                  unused_rem;

  assign unused_rem = ^rb_rem;

  always_comb begin
    f_sum   = {{(WA-PROD_W){1'b0}}, rb_side.prod} + {{(WA-20){1'b0}}, rb_quo[19:0]};
    f_mag   = f_sum[FRAME_BITS-1:0];
    ns_mag  = rb_side.sat ? NSEC_MAX : rb_quo[29:0];
    r_frame = '0;
    r_sec   = '0;
    r_nsec  = '0;
    r_ovf   = 1'b0;
    if (rb_side.cmd == CMD_TIME_TO_FRAME) begin
      if (f_sum > FMAX) begin
        f_mag = FMAX[FRAME_BITS-1:0];
        r_ovf = 1'b1;
      end
      r_frame = rb_side.neg ? (~f_mag + 1'b1) : f_mag;
    end else if (rb_side.rzero) begin
      r_ovf = 1'b1;
    end else begin
      r_ovf  = rb_side.sat;
      r_sec  = rb_side.neg ? (~rb_side.sec + 1'b1) : rb_side.sec;
      r_nsec = rb_side.neg ? (~{1'b0, ns_mag} + 1'b1) : {1'b0, ns_mag};
    end
  end

  // ---- two-entry output queue
  logic [FRAME_BITS-1:0] q_frame [2];
  logic [31:0]           q_sec   [2];
  logic [30:0]           q_nsec  [2];
  logic                  q_ovf   [2];
  logic                  wr_ptr_q;
  logic                  rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  push;
  logic                  pop;

  assign en   = (cnt_q != 2'd2);
  assign push = en && rb_valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_frame[wr_ptr_q] <= r_frame;
      q_sec[wr_ptr_q]   <= r_sec;
      q_nsec[wr_ptr_q]  <= r_nsec;
      q_ovf[wr_ptr_q]   <= r_ovf;
    end
  end

  assign in_ready_o        = en;
  assign out_valid_o       = (cnt_q != 2'd0) && !(unused_rem && 1'b0);
  assign frame_out_o       = q_frame[rd_ptr_q];
  assign seconds_out_o     = q_sec[rd_ptr_q];
  assign nanoseconds_out_o = q_nsec[rd_ptr_q];
  assign overflow_o        = q_ovf[rd_ptr_q];

endmodule

[hw/rtl/sfc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_cell
// One restoring-division step: brings in one dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module sfc_cell #(
  parameter int unsigned W = 62
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  sfc_pkg::sfc_side_t       side_i,
  input  logic [W-1:0]             dvd_i,
  input  logic [sfc_pkg::DSR_W-1:0] rem_i,
  input  logic [sfc_pkg::DSR_W-1:0] dsr_i,
  output logic                     valid_o,
  output sfc_pkg::sfc_side_t       side_o,
  output logic [W-1:0]             dvd_o,
  output logic [sfc_pkg::DSR_W-1:0] rem_o,
  output logic [sfc_pkg::DSR_W-1:0] dsr_o
);
  import sfc_pkg::*;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;
  logic [DSR_W-1:0] rem_d;
  logic [W-1:0]     dvd_d;

  logic             valid_q;
  sfc_side_t        side_q;
  logic [W-1:0]     dvd_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;

  always_comb begin
    trial = {rem_i, dvd_i[W-1]};
    diff  = trial - {1'b0, dsr_i};
    ge    = (trial >= {1'b0, dsr_i});
    rem_d = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    dvd_d = {dvd_i[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign dvd_o   = dvd_q;
  assign rem_o   = rem_q;
  assign dsr_o   = dsr_q;

endmodule

[hw/rtl/sfc_div_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_div_chain
// Row of W division cells: W-bit dividend by 30-bit divisor, one bit per cell.
// ----------------------------------------------------------------------------
module sfc_div_chain #(
  parameter int unsigned W = 62
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  sfc_pkg::sfc_side_t        side_i,
  input  logic [W-1:0]              dvd_i,
  input  logic [sfc_pkg::DSR_W-1:0] dsr_i,
  output logic                      valid_o,
  output sfc_pkg::sfc_side_t        side_o,
  output logic [W-1:0]              quo_o,
  output logic [sfc_pkg::DSR_W-1:0] rem_o
);
  import sfc_pkg::*;

  logic             valid_s [W+1];
  sfc_side_t        side_s  [W+1];
  logic [W-1:0]     dvd_s   [W+1];
  logic [DSR_W-1:0] rem_s   [W+1];
  logic [DSR_W-1:0] dsr_s   [W+1];

  assign valid_s[0] = valid_i;
  assign side_s[0]  = side_i;
  assign dvd_s[0]   = dvd_i;
  assign rem_s[0]   = '0;
  assign dsr_s[0]   = dsr_i;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sfc_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_s[i]),
      .side_i  (side_s[i]),
      .dvd_i   (dvd_s[i]),
      .rem_i   (rem_s[i]),
      .dsr_i   (dsr_s[i]),
      .valid_o (valid_s[i+1]),
      .side_o  (side_s[i+1]),
      .dvd_o   (dvd_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .dsr_o   (dsr_s[i+1])
    );
  end

  assign valid_o = valid_s[W];
  assign side_o  = side_s[W];
  assign quo_o   = dvd_s[W];
  assign rem_o   = rem_s[W];

endmodule
